// ----- rtl/core/interpolated_complex_screened_sum_macros.svh -----
// ----------------------------------------------------------------------------
// interpolated complex screened sum assertion macros
// concurrent assertion forms used by the core controller
// ----------------------------------------------------------------------------
`ifndef INTERPOLATED_COMPLEX_SCREENED_SUM_MACROS_SVH
`define INTERPOLATED_COMPLEX_SCREENED_SUM_MACROS_SVH

// same-cycle implication, disabled during reset
`define ICSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icss assertion failed");

// next-cycle implication, disabled during reset
`define ICSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icss assertion failed");

`endif

// ----- rtl/core/icss_pkg.sv -----
// ----------------------------------------------------------------------------
// icss package
// shared types, codes and saturating helpers of the screened sum core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package icss_pkg;

    localparam int EVAL_POINTS_DEF = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PT_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OCCUPANCY = 2'd2;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

    // micro-steps of one item, each one fixed-point multiply
    typedef enum logic [3:0] {
        ST_ELR_WL, ST_EHR_WH, ST_ELI_WL, ST_EHI_WH,
        ST_MR_BLR, ST_NMI_BLI, ST_MR_BLI, ST_NMI_BLR,
        ST_NR_TR, ST_NI_TI, ST_NR_TI, ST_NI_TR,
        ST_COL_RE, ST_COL_IM, ST_SUM_RE, ST_SUM_IM
    } t_step;

    typedef struct packed {
        logic  mul_start;
        t_step step;
        logic  col_upd;
        logic  tot_rd;
        logic  tot_wr;
        logic  emit;
        logic  clr_wr;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic col_end;
        logic sum_end;
        logic clr_last;
    } t_sts;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            return a[63] ? SAT_MIN : SAT_MAX;
        end
        return s;
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if ((a[63] != b[63]) && (s[63] != a[63])) begin
            return a[63] ? SAT_MIN : SAT_MAX;
        end
        return s;
    endfunction

endpackage

// ----- rtl/core/icss_qmul.sv -----
// ----------------------------------------------------------------------------
// icss fixed-point multiplier
// 64 x 64 signed multiply, floor to 16 fractional bits, saturated; one
// 32 x 32 partial product per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icss_qmul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_q
);
    import icss_pkg::*;

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic         r_done;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_neg;
    logic [63:0]  r_p;
    logic [1:0]   r_psh;
    logic [127:0] r_acc;
    logic signed [63:0] r_q;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] p_shifted;
    logic [111:0] mag;
    logic signed [63:0] n_q;

    assign a_half = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
    assign b_half = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];

    always_comb begin
        case (r_psh)
            2'd0:    p_shifted = {64'd0, r_p};
            2'd1:    p_shifted = {32'd0, r_p, 32'd0};
            2'd2:    p_shifted = {r_p, 64'd0};
            default: p_shifted = '0;
        endcase
    end

    // floor of a negative quotient rounds the magnitude up
    assign mag = r_acc[127:16] + {111'd0, (r_neg && (r_acc[15:0] != 16'd0))};

    always_comb begin
        if (!r_neg) begin
            n_q = (mag[111:63] != '0) ? SAT_MAX : signed'(mag[63:0]);
        end else if ((mag[111:64] != '0) || (mag[63] && (mag[62:0] != '0))) begin
            n_q = SAT_MIN;
        end else begin
            n_q = signed'(64'd0 - mag[63:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[63] ? (64'd0 - unsigned'(i_a)) : unsigned'(i_a);
            r_ub  <= i_b[63] ? (64'd0 - unsigned'(i_b)) : unsigned'(i_b);
            r_neg <= i_a[63] != i_b[63];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt < 3'd4) begin
                r_p   <= a_half * b_half;
                r_psh <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
            end
            if ((r_cnt >= 3'd1) && (r_cnt <= 3'd4)) begin
                r_acc <= r_acc + p_shifted;
            end
            if (r_cnt == 3'd5) begin
                r_q <= n_q;
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// ----- rtl/core/icss_datapath.sv -----
// ----------------------------------------------------------------------------
// icss datapath
// operand capture, configuration, micro-step operand muxing, accumulators,
// per-point total memory and output registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icss_datapath #(
    parameter int EVAL_POINTS = icss_pkg::EVAL_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  icss_pkg::t_cmd                     i_cmd,
    output icss_pkg::t_sts                     o_sts,
    input  logic                               i_load,
    input  logic [287:0]                       i_tdata,
    input  logic                               i_col_end,
    input  logic                               i_sum_end,
    input  logic [icss_pkg::PT_W-1:0]          i_pt,
    input  logic                               i_cfg_we,
    input  logic [icss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [icss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [255:0]                       o_tdata,
    output logic [icss_pkg::PT_W-1:0]          o_pt
);
    import icss_pkg::*;

    localparam int AW = (EVAL_POINTS > 1) ? $clog2(EVAL_POINTS) : 1;

    logic signed [31:0] r_elr, r_eli, r_ehr, r_ehi, r_nr, r_ni, r_mr, r_mi, r_coul;
    logic               r_col_end, r_sum_end;
    logic [PT_W-1:0]    r_pt;
    logic signed [31:0] r_wl, r_wh, r_occ;

    logic signed [63:0] r_tmp, r_blr, r_bli, r_tr, r_ti, r_pr, r_pi;
    logic signed [63:0] r_col_re, r_col_im, r_sum_re, r_sum_im;
    logic signed [63:0] r_scl_re, r_scl_im;
    logic signed [63:0] r_rd_re, r_rd_im;
    logic signed [63:0] r_o_scl_re, r_o_scl_im, r_o_tot_re, r_o_tot_im;
    logic signed [63:0] r_tot_re, r_tot_im;
    logic [PT_W-1:0]    r_o_pt;
    logic [AW-1:0]      r_clr_addr;

    logic signed [63:0] r_mem_re [EVAL_POINTS];
    logic signed [63:0] r_mem_im [EVAL_POINTS];

    logic signed [63:0] mul_a, mul_b, mul_q;
    logic               mul_done;
    logic [AW-1:0]      addr;
    logic               in_range;
    logic signed [63:0] n_tot_re, n_tot_im;

    function automatic logic signed [63:0] sx(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    assign addr     = AW'(r_pt);
    assign in_range = 32'(r_pt) < 32'(EVAL_POINTS);
    assign n_tot_re = sat_add(r_rd_re, r_sum_re);
    assign n_tot_im = sat_add(r_rd_im, r_sum_im);

    always_comb begin
        case (i_cmd.step)
            ST_ELR_WL:  begin mul_a = sx(r_elr);           mul_b = sx(r_wl);  end
            ST_EHR_WH:  begin mul_a = sx(r_ehr);           mul_b = sx(r_wh);  end
            ST_ELI_WL:  begin mul_a = sx(r_eli);           mul_b = sx(r_wl);  end
            ST_EHI_WH:  begin mul_a = sx(r_ehi);           mul_b = sx(r_wh);  end
            ST_MR_BLR:  begin mul_a = sx(r_mr);            mul_b = r_blr;     end
            ST_NMI_BLI: begin mul_a = 64'sd0 - sx(r_mi);   mul_b = r_bli;     end
            ST_MR_BLI:  begin mul_a = sx(r_mr);            mul_b = r_bli;     end
            ST_NMI_BLR: begin mul_a = 64'sd0 - sx(r_mi);   mul_b = r_blr;     end
            ST_NR_TR:   begin mul_a = sx(r_nr);            mul_b = r_tr;      end
            ST_NI_TI:   begin mul_a = sx(r_ni);            mul_b = r_ti;      end
            ST_NR_TI:   begin mul_a = sx(r_nr);            mul_b = r_ti;      end
            ST_NI_TR:   begin mul_a = sx(r_ni);            mul_b = r_tr;      end
            ST_COL_RE:  begin mul_a = r_col_re;            mul_b = sx(r_coul); end
            ST_COL_IM:  begin mul_a = r_col_im;            mul_b = sx(r_coul); end
            ST_SUM_RE:  begin mul_a = r_sum_re;            mul_b = sx(r_occ); end
            ST_SUM_IM:  begin mul_a = r_sum_im;            mul_b = sx(r_occ); end
            default:    begin mul_a = '0;                  mul_b = '0;        end
        endcase
    end

    icss_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_q     (mul_q)
    );

    // configuration and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl       <= '0;
            r_wh       <= '0;
            r_occ      <= 32'sd65536;
            r_col_re   <= '0;
            r_col_im   <= '0;
            r_sum_re   <= '0;
            r_sum_im   <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WEIGHT_LOW:  r_wl  <= signed'(i_cfg_data);
                    CFG_WEIGHT_HIGH: r_wh  <= signed'(i_cfg_data);
                    CFG_OCCUPANCY:   r_occ <= signed'(i_cfg_data);
                    default:         ;
                endcase
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.col_upd) begin
                r_col_re <= sat_add(r_col_re, r_pr);
                r_col_im <= sat_add(r_col_im, r_pi);
            end
            if (mul_done) begin
                case (i_cmd.step)
                    ST_COL_RE: r_sum_re <= sat_add(r_sum_re, mul_q);
                    ST_COL_IM: begin
                        r_sum_im <= sat_add(r_sum_im, mul_q);
                        r_col_re <= '0;
                        r_col_im <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.tot_wr) begin
                r_sum_re <= '0;
                r_sum_im <= '0;
            end
        end
    end

    // item capture and intermediate products
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_elr     <= signed'(i_tdata[31:0]);
            r_eli     <= signed'(i_tdata[63:32]);
            r_ehr     <= signed'(i_tdata[95:64]);
            r_ehi     <= signed'(i_tdata[127:96]);
            r_nr      <= signed'(i_tdata[159:128]);
            r_ni      <= signed'(i_tdata[191:160]);
            r_mr      <= signed'(i_tdata[223:192]);
            r_mi      <= signed'(i_tdata[255:224]);
            r_coul    <= signed'(i_tdata[287:256]);
            r_col_end <= i_col_end;
            r_sum_end <= i_sum_end;
            r_pt      <= i_pt;
        end
        if (mul_done) begin
            case (i_cmd.step)
                ST_ELR_WL, ST_ELI_WL, ST_MR_BLR, ST_MR_BLI,
                ST_NR_TR, ST_NR_TI: r_tmp <= mul_q;
                ST_EHR_WH:  r_blr    <= sat_add(r_tmp, mul_q);
                ST_EHI_WH:  r_bli    <= sat_add(r_tmp, mul_q);
                ST_NMI_BLI: r_tr     <= sat_sub(r_tmp, mul_q);
                ST_NMI_BLR: r_ti     <= sat_add(r_tmp, mul_q);
                ST_NI_TI:   r_pr     <= sat_sub(r_tmp, mul_q);
                ST_NI_TR:   r_pi     <= sat_add(r_tmp, mul_q);
                ST_SUM_RE:  r_scl_re <= mul_q;
                ST_SUM_IM:  r_scl_im <= mul_q;
                default:    ;
            endcase
        end
        if (i_cmd.tot_wr) begin
            r_tot_re <= in_range ? n_tot_re : 64'sd0;
            r_tot_im <= in_range ? n_tot_im : 64'sd0;
        end
        if (i_cmd.emit) begin
            r_o_scl_re <= r_scl_re;
            r_o_scl_im <= r_scl_im;
            r_o_tot_re <= r_tot_re;
            r_o_tot_im <= r_tot_im;
            r_o_pt     <= r_pt;
        end
    end

    // running totals per evaluation point
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem_re[r_clr_addr] <= '0;
            r_mem_im[r_clr_addr] <= '0;
        end else if (i_cmd.tot_wr && in_range) begin
            r_mem_re[addr] <= n_tot_re;
            r_mem_im[addr] <= n_tot_im;
        end
        if (i_cmd.tot_rd) begin
            r_rd_re <= r_mem_re[addr];
            r_rd_im <= r_mem_im[addr];
        end
    end

    assign o_sts.mul_done = mul_done;
    assign o_sts.col_end  = r_col_end;
    assign o_sts.sum_end  = r_sum_end;
    assign o_sts.clr_last = r_clr_addr == AW'(EVAL_POINTS - 1);

    assign o_tdata = {r_o_tot_im, r_o_tot_re, r_o_scl_im, r_o_scl_re};
    assign o_pt    = r_o_pt;

endmodule

// ----- rtl/core/icss_ctrl.sv -----
// ----------------------------------------------------------------------------
// icss controller
// sequences the clearing pass, the multiply micro-steps, the total update
// and the result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  icss_pkg::t_sts i_sts,
    output icss_pkg::t_cmd o_cmd,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_load,
    output logic           o_out_valid,
    input  logic           i_out_ready
);
    import icss_pkg::*;
    `include "interpolated_complex_screened_sum_macros.svh"

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MUL_GO, S_MUL_WAIT, S_COL_UPD, S_TOT_RD, S_TOT_WR, S_EMIT
    } t_state;

    t_state r_state;
    t_step  r_step;
    logic   r_out_valid;
    logic   emit_ok;

    assign emit_ok    = !r_out_valid || i_out_ready;
    assign o_in_ready = r_state == S_IDLE;
    assign o_load     = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.step      = r_step;
        o_cmd.mul_start = r_state == S_MUL_GO;
        o_cmd.col_upd   = r_state == S_COL_UPD;
        o_cmd.tot_rd    = r_state == S_TOT_RD;
        o_cmd.tot_wr    = r_state == S_TOT_WR;
        o_cmd.emit      = (r_state == S_EMIT) && emit_ok;
        o_cmd.clr_wr    = r_state == S_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= ST_ELR_WL;
            r_out_valid <= 1'b0;
        end else begin
            // a new result replaces the one leaving in the same cycle
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_step  <= ST_ELR_WL;
                        r_state <= S_MUL_GO;
                    end
                end
                S_MUL_GO: begin
                    r_state <= S_MUL_WAIT;
                end
                S_MUL_WAIT: begin
                    if (i_sts.mul_done) begin
                        case (r_step)
                            ST_NI_TR:  r_state <= S_COL_UPD;
                            ST_COL_IM: begin
                                if (i_sts.sum_end) begin
                                    r_step  <= ST_SUM_RE;
                                    r_state <= S_MUL_GO;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                            ST_SUM_IM: r_state <= S_TOT_RD;
                            default: begin
                                r_step  <= t_step'(r_step + 4'd1);
                                r_state <= S_MUL_GO;
                            end
                        endcase
                    end
                end
                S_COL_UPD: begin
                    if (i_sts.col_end || i_sts.sum_end) begin
                        r_step  <= ST_COL_RE;
                        r_state <= S_MUL_GO;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_TOT_RD: r_state <= S_TOT_WR;
                S_TOT_WR: r_state <= S_EMIT;
                S_EMIT: begin
                    if (emit_ok) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    `ICSS_ASSERT_SAME(a_emit_slot_free, i_clk, i_rst_n, o_cmd.emit, (!r_out_valid || i_out_ready))
    `ICSS_ASSERT_NEXT(a_emit_sets_valid, i_clk, i_rst_n, o_cmd.emit, r_out_valid)
    `ICSS_ASSERT_SAME(a_done_when_waiting, i_clk, i_rst_n, i_sts.mul_done, (r_state == S_MUL_WAIT))
    `ICSS_ASSERT_NEXT(a_start_then_wait, i_clk, i_rst_n, o_cmd.mul_start, (r_state == S_MUL_WAIT))

endmodule

// ----- rtl/core/interpolated_complex_screened_sum.sv -----
// ----------------------------------------------------------------------------
// interpolated complex screened sum
// blends dielectric entries, applies band coefficients, accumulates columns
// and sums, and keeps saturated running totals per evaluation point
// ----------------------------------------------------------------------------
// usage:
// - slave stream carries one entry per transaction; s_axis_tlast marks the
//   end of the whole sum, s_axis_tuser carries the column-end flag and the
//   evaluation point index
// - master stream delivers one result transaction per sum, tuser holding the
//   evaluation point, tdata the scaled sum and the updated running total
// - config writes through i_cfg_we / i_cfg_idx / i_cfg_data while idle
// - after reset a clearing pass zeroes the running totals, with
//   s_axis_tready low
// - every fixed-point multiply runs on the single shared 32 x 32
//   partial-product multiplier; an entry needs 12 multiplies plus a column
//   update and is taken only once the previous one is through, a column
//   end or sum end adds 2 multiplies, and a sum end 2 more plus the total
//   memory read-modify-write and hand-off
// - the result sits in an output register; the next entry is taken while it
//   waits, and a stalled receiver only holds the block at the next result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interpolated_complex_screened_sum #(
    parameter int EVAL_POINTS = icss_pkg::EVAL_POINTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // eps_low_re, eps_low_im, eps_high_re, eps_high_im, band_n_re, band_n_im,
    // band_m_re, band_m_im, coulomb
    input  logic [287:0]                    s_axis_tdata,
    input  logic                            s_axis_tlast,   // sum_end
    // column_end, eval_point
    input  logic [4:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // scaled_re, scaled_im, total_re, total_im
    output logic [255:0]                    m_axis_tdata,
    // out_eval_point
    output logic [3:0]                      m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [icss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [icss_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import icss_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic load;

    // sequencing of multiply steps, total update and result hand-off
    icss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_load      (load),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    // arithmetic, accumulators and running total memory
    icss_datapath #(
        .EVAL_POINTS (EVAL_POINTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_load     (load),
        .i_tdata    (s_axis_tdata),
        .i_col_end  (s_axis_tuser[0]),
        .i_sum_end  (s_axis_tlast),
        .i_pt       (s_axis_tuser[4:1]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_tdata    (m_axis_tdata),
        .o_pt       (m_axis_tuser)
    );

endmodule
